// ===== sv/vcfc_pkg.sv =====
// Package for the voxel chunk face culler: field widths, command and state
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package vcfc_pkg;

    localparam int GRID_SIDE_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int COORD_W  = 6;
    localparam int RADIUS_W = 7;
    localparam int VSIZE_W  = 10;
    localparam int R2W      = 2 * RADIUS_W;
    localparam int FACE_W   = 3;
    localparam int POS_W    = 16;
    localparam int VTX_W    = 20;
    localparam int NFACE    = 6;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [VTX_W-1:0]  VTX_STEP  = VTX_W'(4);
    localparam logic [FACE_W-1:0] FACE_NONE = '0;

    // register index, taken from paddr[2]
    localparam logic REG_SPHERE_RADIUS = 1'b0;
    localparam logic REG_VOXEL_SIZE    = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(8);
    localparam logic [VSIZE_W-1:0]  VSIZE_RST  = VSIZE_W'(100);

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL    = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_MESH    = 2'd2,
        CMD_RESTART = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        RD_CENTER,
        RD_XM,
        RD_XP,
        RD_YM,
        RD_YP
    } t_rd_sel;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_RM_RD,
        ST_RM_WR,
        ST_MC,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    row_clr;
        logic    row_step;
        logic    wr_zero;
        logic    wr_fill;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_en;
        t_rd_sel cap_sel;
        logic    rm_out;
        logic    emit;
        logic    vtx_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic in_grid;
        logic center_solid;
        logic row_last;
        logic out_free;
        logic vis_any;
        logic vis_last;
    } t_dp_status;

endpackage

// ===== sv/vcfc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module vcfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/vcfc_ctrl.sv =====
// Controller of the face culler: sequences clear pass, fill, remove and mesh, and handles restart.
// Depends on vcfc_pkg; drives vcfc_dp through t_dp_cmd.
module vcfc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [vcfc_pkg::CMD_W-1:0] i_command,
    output logic                      o_in_stall,
    input  vcfc_pkg::t_dp_status      i_status,
    output vcfc_pkg::t_dp_cmd         o_cmd
);
    import vcfc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_zero  = 1'b1;
                o_cmd.row_step = 1'b1;
                if (i_status.row_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    unique case (t_command'(i_command))
                        CMD_FILL: begin
                            o_cmd.row_clr = 1'b1;
                            n_state       = ST_FILL;
                        end
                        CMD_REMOVE: n_state = ST_RM_RD;
                        CMD_MESH: begin
                            if (i_status.in_grid) begin
                                n_state = ST_MC;
                            end
                        end
                        CMD_RESTART: o_cmd.vtx_clr = 1'b1;
                    endcase
                end
            end
            ST_FILL: begin
                o_cmd.wr_fill  = 1'b1;
                o_cmd.row_step = 1'b1;
                if (i_status.row_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RM_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CENTER;
                n_state      = ST_RM_WR;
            end
            ST_RM_WR: begin
                if (i_status.out_free) begin
                    o_cmd.rm_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_MC: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CENTER;
                n_state      = ST_M1;
            end
            ST_M1: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_CENTER;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_XM;
                n_state       = i_status.center_solid ? ST_M2 : ST_IDLE;
            end
            ST_M2: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_XM;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_XP;
                n_state       = ST_M3;
            end
            ST_M3: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_XP;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_YM;
                n_state       = ST_M4;
            end
            ST_M4: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_YM;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_YP;
                n_state       = ST_M5;
            end
            ST_M5: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_YP;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_status.vis_any) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.vis_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/vcfc_dp.sv =====
// Datapath of the face culler: occupancy RAM (one row of z bits per x,y),
// row sweep counters, sphere row builder, face mask, vertex count, result register.
// Depends on vcfc_pkg and vcfc_ram; steered by vcfc_ctrl through t_dp_cmd.
module vcfc_dp #(
    parameter int GRID_SIDE = vcfc_pkg::GRID_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vcfc_pkg::t_dp_cmd            i_cmd,
    output vcfc_pkg::t_dp_status         o_status,
    input  logic [vcfc_pkg::COORD_W-1:0]  i_x_index,
    input  logic [vcfc_pkg::COORD_W-1:0]  i_y_index,
    input  logic [vcfc_pkg::COORD_W-1:0]  i_z_index,
    input  logic [vcfc_pkg::RADIUS_W-1:0] i_sphere_radius,
    input  logic [vcfc_pkg::VSIZE_W-1:0]  i_voxel_size,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_has_face,
    output logic [vcfc_pkg::FACE_W-1:0]   o_face,
    output logic [vcfc_pkg::POS_W-1:0]    o_pos_x,
    output logic [vcfc_pkg::POS_W-1:0]    o_pos_y,
    output logic [vcfc_pkg::POS_W-1:0]    o_pos_z,
    output logic [vcfc_pkg::VTX_W-1:0]    o_first_vertex,
    output logic                         o_removed,
    output logic                         o_last
);
    import vcfc_pkg::*;

    localparam int AW    = $clog2(GRID_SIDE);
    localparam int RAW   = 2 * AW;
    localparam int DEPTH = 1 << RAW;
    localparam int D2W   = 2 * AW;
    localparam int CW    = (D2W > R2W) ? D2W : R2W;
    localparam logic [AW-1:0]        LAST_IDX = AW'(GRID_SIDE - 1);
    localparam logic [AW-1:0]        CTR      = AW'(GRID_SIDE / 2);
    localparam logic [GRID_SIDE-1:0] ONE_BIT  = GRID_SIDE'(1);

    function automatic logic [AW-1:0] dist_ctr(input logic [AW-1:0] v);
        return (v >= CTR) ? AW'(v - CTR) : AW'(CTR - v);
    endfunction

    logic [AW-1:0]        r_x, r_y, r_z;
    logic                 r_inside;
    logic [POS_W-1:0]     r_pos_x, r_pos_y, r_pos_z;
    logic [R2W-1:0]       r_r2;
    logic [AW-1:0]        r_cx, r_cy;
    logic                 r_wr_vld;
    logic [RAW-1:0]       r_wr_addr;
    logic                 r_wr_fill;
    logic [GRID_SIDE-1:0] r_wr_row;
    logic [D2W-1:0]       r_dxy2;
    logic [NFACE-1:0]     r_vis;
    logic [VTX_W-1:0]     r_vtx;
    logic                 r_o_vld;
    logic                 r_res_has_face;
    logic [FACE_W-1:0]    r_res_face;
    logic [POS_W-1:0]     r_res_pos_x, r_res_pos_y, r_res_pos_z;
    logic [VTX_W-1:0]     r_res_vtx;
    logic                 r_res_removed;
    logic                 r_res_last;

    logic                 in_inside;
    logic [AW-1:0]        ax, ay;
    logic [D2W-1:0]       sq_x, sq_y;
    logic [GRID_SIDE-1:0] fill_row;
    logic [GRID_SIDE-1:0] wdata;
    logic [GRID_SIDE-1:0] rd_row;
    logic [RAW-1:0]       rd_addr;
    logic [RAW-1:0]       ctr_addr;
    logic                 bit_z, bit_zm, bit_zp;
    logic                 row_last;
    logic                 out_free;
    logic                 vis_last;
    logic [FACE_W-1:0]    emit_face;

    assign in_inside = ((COORD_W + 1)'(i_x_index) < (COORD_W + 1)'(GRID_SIDE))
                    && ((COORD_W + 1)'(i_y_index) < (COORD_W + 1)'(GRID_SIDE))
                    && ((COORD_W + 1)'(i_z_index) < (COORD_W + 1)'(GRID_SIDE));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= i_x_index[AW-1:0];
            r_y      <= i_y_index[AW-1:0];
            r_z      <= i_z_index[AW-1:0];
            r_inside <= in_inside;
            r_pos_x  <= POS_W'(i_x_index) * POS_W'(i_voxel_size);
            r_pos_y  <= POS_W'(i_y_index) * POS_W'(i_voxel_size);
            r_pos_z  <= POS_W'(i_z_index) * POS_W'(i_voxel_size);
            r_r2     <= R2W'(i_sphere_radius) * R2W'(i_sphere_radius);
        end
    end

    // row sweep over x,y < GRID_SIDE
    assign row_last = (r_cx == LAST_IDX) && (r_cy == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.row_clr) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cmd.row_step) begin
            if (r_cy == LAST_IDX) begin
                r_cy <= '0;
                r_cx <= (r_cx == LAST_IDX) ? '0 : AW'(r_cx + 1'b1);
            end else begin
                r_cy <= AW'(r_cy + 1'b1);
            end
        end
    end

    assign ax   = dist_ctr(r_cx);
    assign ay   = dist_ctr(r_cy);
    assign sq_x = D2W'(ax) * D2W'(ax);
    assign sq_y = D2W'(ay) * D2W'(ay);

    assign ctr_addr = {r_x, r_y};

    // write stage: a row write request is registered before it reaches the RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= 1'b0;
        end else begin
            r_wr_vld <= i_cmd.wr_zero || i_cmd.wr_fill || (i_cmd.rm_out && r_inside);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_zero || i_cmd.wr_fill) begin
            r_wr_addr <= {r_cx, r_cy};
            r_wr_fill <= i_cmd.wr_fill;
            r_wr_row  <= '0;
            r_dxy2    <= D2W'(sq_x + sq_y);
        end else if (i_cmd.rm_out) begin
            r_wr_addr <= ctr_addr;
            r_wr_fill <= 1'b0;
            r_wr_row  <= rd_row & ~(ONE_BIT << r_z);
        end
    end

    for (genvar gz = 0; gz < GRID_SIDE; gz++) begin : g_lane
        localparam int DZ = (gz >= GRID_SIDE / 2) ? gz - GRID_SIDE / 2 : GRID_SIDE / 2 - gz;
        localparam logic [D2W-1:0] DZ2 = D2W'(DZ * DZ);
        logic [D2W-1:0] d2;
        assign d2           = D2W'(r_dxy2 + DZ2);
        assign fill_row[gz] = (CW'(d2) <= CW'(r_r2));
    end

    assign wdata = r_wr_fill ? fill_row : r_wr_row;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_CENTER: rd_addr = ctr_addr;
            RD_XM:     rd_addr = {AW'(r_x - 1'b1), r_y};
            RD_XP:     rd_addr = {AW'(r_x + 1'b1), r_y};
            RD_YM:     rd_addr = {r_x, AW'(r_y - 1'b1)};
            RD_YP:     rd_addr = {r_x, AW'(r_y + 1'b1)};
            default:   rd_addr = ctr_addr;
        endcase
    end

    vcfc_ram #(
        .WIDTH (GRID_SIDE),
        .DEPTH (DEPTH)
    ) u_occ (
        .i_clk   (i_clk),
        .i_we    (r_wr_vld),
        .i_waddr (r_wr_addr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_row)
    );

    assign bit_z  = rd_row[r_z];
    assign bit_zm = (r_z != '0) && rd_row[AW'(r_z - 1'b1)];
    assign bit_zp = (r_z != LAST_IDX) && rd_row[AW'(r_z + 1'b1)];

    // lowest visible face first
    always_comb begin
        emit_face = FACE_NONE;
        for (int f = NFACE - 1; f >= 0; f--) begin
            if (r_vis[f]) begin
                emit_face = FACE_W'(f);
            end
        end
    end

    assign vis_last = (r_vis != '0) && ((r_vis & NFACE'(r_vis - 1'b1)) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_vis <= '0;
        end else if (i_cmd.cap_en) begin
            unique case (i_cmd.cap_sel)
                RD_CENTER: begin
                    r_vis[4] <= !bit_zm;
                    r_vis[5] <= !bit_zp;
                end
                RD_XM:   r_vis[0] <= !((r_x != '0) && bit_z);
                RD_XP:   r_vis[1] <= !((r_x != LAST_IDX) && bit_z);
                RD_YM:   r_vis[2] <= !((r_y != '0) && bit_z);
                RD_YP:   r_vis[3] <= !((r_y != LAST_IDX) && bit_z);
                default: r_vis <= r_vis;
            endcase
        end else if (i_cmd.emit) begin
            r_vis[emit_face] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.vtx_clr) begin
            r_vtx <= '0;
        end else if (i_cmd.emit) begin
            r_vtx <= r_vtx + VTX_STEP;
        end
    end

    // result register
    assign out_free = !r_o_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_cmd.emit || i_cmd.rm_out) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res_has_face <= 1'b1;
            r_res_face     <= emit_face;
            r_res_pos_x    <= r_pos_x;
            r_res_pos_y    <= r_pos_y;
            r_res_pos_z    <= r_pos_z;
            r_res_vtx      <= r_vtx;
            r_res_removed  <= 1'b0;
            r_res_last     <= vis_last;
        end else if (i_cmd.rm_out) begin
            r_res_has_face <= 1'b0;
            r_res_face     <= FACE_NONE;
            r_res_pos_x    <= '0;
            r_res_pos_y    <= '0;
            r_res_pos_z    <= '0;
            r_res_vtx      <= '0;
            r_res_removed  <= r_inside && bit_z;
            r_res_last     <= 1'b1;
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_has_face     = r_res_has_face;
    assign o_face         = r_res_face;
    assign o_pos_x        = r_res_pos_x;
    assign o_pos_y        = r_res_pos_y;
    assign o_pos_z        = r_res_pos_z;
    assign o_first_vertex = r_res_vtx;
    assign o_removed      = r_res_removed;
    assign o_last         = r_res_last;

    assign o_status.in_grid      = in_inside;
    assign o_status.center_solid = bit_z;
    assign o_status.row_last     = row_last;
    assign o_status.out_free     = out_free;
    assign o_status.vis_any      = (r_vis != '0);
    assign o_status.vis_last     = vis_last;

endmodule

// ===== sv/voxel_chunk_face_culler_core.sv =====
// Top level of the voxel chunk face culler: APB register file, controller
// and datapath. Depends on vcfc_pkg, vcfc_ctrl, vcfc_dp (and vcfc_ram below it).
//
//   channel  direction  handshake                 payload
//   in       to core    i_in_valid / o_in_stall   command, x/y/z index
//   out      from core  o_out_valid / i_out_stall has_face .. last
//   cfg      to core    APB psel/penable/pready   sphere_radius, voxel_size
//
// Fill writes one z row of the occupancy RAM a cycle until all GRID_SIDE*GRID_SIDE
// rows are done; remove reads the centre row and, inside the grid, writes it back
// with the z bit cleared; restart clears the vertex count; mesh of a solid voxel
// emits one result per visible face, reading five RAM rows in turn on its single read port.
// After reset a clearing pass zeroes every row of the grid while o_in_stall stays high;
// register writes are taken throughout. A stalled result holds in the output register;
// no new request is taken until the current one is done, and only remove and mesh of
// a voxel with visible faces place their final result in the output register.
module voxel_chunk_face_culler_core #(
    parameter int GRID_SIDE = vcfc_pkg::GRID_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [vcfc_pkg::CMD_W-1:0]    i_command,
    input  logic [vcfc_pkg::COORD_W-1:0]  i_x_index,
    input  logic [vcfc_pkg::COORD_W-1:0]  i_y_index,
    input  logic [vcfc_pkg::COORD_W-1:0]  i_z_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_has_face,
    output logic [vcfc_pkg::FACE_W-1:0]   o_face,
    output logic [vcfc_pkg::POS_W-1:0]    o_pos_x,
    output logic [vcfc_pkg::POS_W-1:0]    o_pos_y,
    output logic [vcfc_pkg::POS_W-1:0]    o_pos_z,
    output logic [vcfc_pkg::VTX_W-1:0]    o_first_vertex,
    output logic                          o_removed,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vcfc_pkg::APB_AW-1:0]   paddr,
    input  logic [vcfc_pkg::APB_DW-1:0]   pwdata,
    output logic [vcfc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import vcfc_pkg::*;

    logic [RADIUS_W-1:0] r_sphere_radius;
    logic [VSIZE_W-1:0]  r_voxel_size;
    logic                cfg_wr;
    logic                reg_idx;
    t_dp_cmd             dp_cmd;
    t_dp_status          dp_status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sphere_radius <= RADIUS_RST;
            r_voxel_size    <= VSIZE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SPHERE_RADIUS: r_sphere_radius <= pwdata[RADIUS_W-1:0];
                REG_VOXEL_SIZE:    r_voxel_size    <= pwdata[VSIZE_W-1:0];
                default:           r_voxel_size    <= r_voxel_size;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SPHERE_RADIUS: prdata = APB_DW'(r_sphere_radius);
            REG_VOXEL_SIZE:    prdata = APB_DW'(r_voxel_size);
            default:           prdata = '0;
        endcase
    end

    vcfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    vcfc_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_x_index       (i_x_index),
        .i_y_index       (i_y_index),
        .i_z_index       (i_z_index),
        .i_sphere_radius (r_sphere_radius),
        .i_voxel_size    (r_voxel_size),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_has_face      (o_has_face),
        .o_face          (o_face),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_first_vertex  (o_first_vertex),
        .o_removed       (o_removed),
        .o_last          (o_last)
    );

    a_remove_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_removed |-> o_last && !o_has_face)
        else $error("remove result with face or without last");

    a_face_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_face |-> (o_face <= FACE_W'(NFACE - 1)) && !o_removed)
        else $error("face result with bad face code or removed flag");

    a_single_nonface: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_face |-> o_last)
        else $error("non-face result not marked last");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
